### rtl/core/srec_pkg.sv
// ----------------------------------------------------------------------------
// srec_pkg
// Shared constants, types and helpers of the S-record encoder.
// ----------------------------------------------------------------------------
package srec_pkg;

   // Default number of data bytes in one S3 record
   localparam int RECORD_BYTES_DEF = 32;

   // Payload widths
   localparam int DATA_W = 8;
   localparam int CHAR_W = 7;

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_BASE_ADDRESS = 1'b0;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_S    = 7'h53;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_3    = 7'h33;
   localparam logic [CHAR_W-1:0] CHAR_7    = 7'h37;
   localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_CR   = 7'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF   = 7'h0A;

   // Count byte minus data length: address bytes plus checksum
   localparam logic [7:0] COUNT_EXTRA_S0 = 8'd3;
   localparam logic [7:0] COUNT_EXTRA_S3 = 8'd5;

   // Index of the most significant address byte
   localparam logic [1:0] ADDR_TOP_S0 = 2'd1;
   localparam logic [1:0] ADDR_TOP_S3 = 2'd3;

   typedef enum logic [1:0] {
      REC_S0,
      REC_S3,
      REC_S7
   } kind_type;

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_COUNT,
      PH_ADDR,
      PH_DATA,
      PH_SUM,
      PH_CRLF
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BYTE,
      ST_CHECK,
      ST_EOF,
      ST_TYPE,
      ST_COUNT,
      ST_ADDR,
      ST_DATA,
      ST_SUM,
      ST_CRLF
   } state_type;

   typedef struct packed {
      logic      load_item;
      logic      append;
      logic      start_record;
      kind_type  kind;
      logic      emit;
      phase_type phase;
      logic      last;
      logic      clr_fill;
      logic      clr_header;
   } ctrl_cmd_type;

   typedef struct packed {
      logic     out_free;
      logic     header_sent;
      logic     fill_zero;
      logic     fill_full;
      logic     item_has;
      logic     item_eof;
      logic     addr_last;
      logic     data_last;
      logic     data_empty;
      kind_type kind;
   } ctrl_status_type;

   // Upper-case hex digit of a nibble
   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {3'b000, nib};
      end else begin
         c = CHAR_A + {3'b000, nib} - 7'd10;
      end
      return c;
   endfunction

   // Record type character
   function automatic logic [CHAR_W-1:0] type_char(input kind_type kind);
      logic [CHAR_W-1:0] c;
      unique case (kind)
         REC_S0:  c = CHAR_ZERO;
         REC_S3:  c = CHAR_3;
         REC_S7:  c = CHAR_7;
         default: c = CHAR_ZERO;
      endcase
      return c;
   endfunction

endpackage

### rtl/core/srec_if.sv
// ----------------------------------------------------------------------------
// srec_req_if / srec_rsp_if
// Valid/ready channels carrying image bytes in and character pairs out.
// ----------------------------------------------------------------------------
interface srec_req_if;
   import srec_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              has_byte;
   logic              end_of_file;

   modport source (output valid, output data_byte, output has_byte,
                   output end_of_file, input ready);
   modport sink (input valid, input data_byte, input has_byte,
                 input end_of_file, output ready);
endinterface

interface srec_rsp_if;
   import srec_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] first_char;
   logic [CHAR_W-1:0] second_char;
   logic              line_end;
   logic              last_of_run;

   modport source (output valid, output first_char, output second_char,
                   output line_end, output last_of_run, input ready);
   modport sink (input valid, input first_char, input second_char,
                 input line_end, input last_of_run, output ready);
endinterface

### rtl/core/srec_ctrl.sv
// ----------------------------------------------------------------------------
// srec_ctrl
// Sequencer: walks items through header, byte append, record emission and
// end-of-file handling, one character pair per cycle while output is free.
// ----------------------------------------------------------------------------
module srec_ctrl #(
   parameter int RECORD_BYTES = srec_pkg::RECORD_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_has_byte,
   input  logic                    req_end_of_file,
   output logic                    req_ready,
   input  srec_pkg::ctrl_status_type status,
   output srec_pkg::ctrl_cmd_type  cmd
);
   import srec_pkg::*;

   localparam bit ONE_BYTE_RECORD = (RECORD_BYTES == 1);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // drop idle transactions, keep the rest
            if (req_valid && (req_has_byte || req_end_of_file)) begin
               cmd.load_item = 1'b1;
               state_in      = ST_BYTE;
            end
         end
         ST_BYTE: begin
            if (!status.header_sent) begin
               cmd.start_record = 1'b1;
               cmd.kind         = REC_S0;
               state_in         = ST_TYPE;
            end else begin
               cmd.append = status.item_has;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK, ST_EOF: begin
            if (state_ff == ST_CHECK && status.fill_full) begin
               cmd.start_record = 1'b1;
               cmd.kind         = REC_S3;
               state_in         = ST_TYPE;
            end else if (!status.item_eof) begin
               state_in = ST_IDLE;
            end else if (!status.fill_zero) begin
               // flush the partial record
               cmd.start_record = 1'b1;
               cmd.kind         = REC_S3;
               state_in         = ST_TYPE;
            end else begin
               cmd.start_record = 1'b1;
               cmd.kind         = REC_S7;
               state_in         = ST_TYPE;
            end
         end
         ST_TYPE: begin
            cmd.phase = PH_TYPE;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.phase = PH_COUNT;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.phase = PH_ADDR;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.addr_last) begin
                  state_in = status.data_empty ? ST_SUM : ST_DATA;
               end
            end
         end
         ST_DATA: begin
            cmd.phase = PH_DATA;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.data_last) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            cmd.phase = PH_SUM;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_CRLF;
            end
         end
         ST_CRLF: begin
            cmd.phase = PH_CRLF;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               unique case (status.kind)
                  REC_S0: begin
                     cmd.last = !status.item_eof &&
                                !(status.item_has && ONE_BYTE_RECORD);
                     state_in = ST_BYTE;
                  end
                  REC_S3: begin
                     cmd.last     = !status.item_eof;
                     cmd.clr_fill = 1'b1;
                     state_in     = ST_EOF;
                  end
                  REC_S7: begin
                     cmd.last       = 1'b1;
                     cmd.clr_fill   = 1'b1;
                     cmd.clr_header = 1'b1;
                     state_in       = ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("pair emitted while output register busy");

   a_s7_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRLF && cmd.emit && status.kind == REC_S7)
      |=> (state_ff == ST_IDLE && !status.header_sent))
      else $error("end record did not close the image");

   a_data_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DATA) |-> !status.data_empty)
      else $error("data phase entered for an empty record");

endmodule

### rtl/core/srec_dp.sv
// ----------------------------------------------------------------------------
// srec_dp
// Datapath: record buffer, address and fill registers, checksum, hex
// formatting and the output register.
// ----------------------------------------------------------------------------
module srec_dp #(
   parameter int RECORD_BYTES = srec_pkg::RECORD_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  srec_pkg::ctrl_cmd_type          cmd,
   output srec_pkg::ctrl_status_type       status,
   input  logic [31:0]                     base_address,
   input  logic [srec_pkg::DATA_W-1:0]     req_data_byte,
   input  logic                            req_has_byte,
   input  logic                            req_end_of_file,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [srec_pkg::CHAR_W-1:0]     rsp_first_char,
   output logic [srec_pkg::CHAR_W-1:0]     rsp_second_char,
   output logic                            rsp_line_end,
   output logic                            rsp_last_of_run
);
   import srec_pkg::*;

   localparam int FILL_W = $clog2(RECORD_BYTES + 1);
   localparam int ADDR_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

   logic [DATA_W-1:0] buffer_mem [RECORD_BYTES];
   logic [DATA_W-1:0] rd_data_ff;

   logic [DATA_W-1:0] item_data_ff;
   logic              item_has_ff;
   logic              item_eof_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [31:0]       next_addr_ff;
   logic [31:0]       rec_addr_ff;
   logic              header_ff;

   kind_type          kind_ff;
   logic [FILL_W-1:0] dlen_ff;
   logic [7:0]        count_ff;
   logic [31:0]       emit_addr_ff;
   logic [1:0]        addr_idx_ff;
   logic [FILL_W-1:0] data_idx_ff;
   logic [7:0]        sum_ff;

   logic              rsp_valid_ff;
   logic [CHAR_W-1:0] first_ff;
   logic [CHAR_W-1:0] second_ff;
   logic              line_end_ff;
   logic              last_ff;

   logic [FILL_W-1:0] dlen_in;
   logic [7:0]        count_in;
   logic [31:0]       emit_addr_in;
   logic [1:0]        addr_idx_in;
   logic [FILL_W-1:0] data_idx_in;
   logic [ADDR_W-1:0] rd_idx;
   logic [7:0]        hex_byte;
   logic [CHAR_W-1:0] first_in;
   logic [CHAR_W-1:0] second_in;
   logic              emit_data;

   // Record setup values
   always_comb begin
      unique case (cmd.kind)
         REC_S0: begin
            dlen_in      = '0;
            emit_addr_in = '0;
            addr_idx_in  = ADDR_TOP_S0;
            count_in     = COUNT_EXTRA_S0;
         end
         REC_S3: begin
            dlen_in      = fill_ff;
            emit_addr_in = rec_addr_ff;
            addr_idx_in  = ADDR_TOP_S3;
            count_in     = 8'(fill_ff) + COUNT_EXTRA_S3;
         end
         REC_S7: begin
            dlen_in      = '0;
            emit_addr_in = base_address;
            addr_idx_in  = ADDR_TOP_S3;
            count_in     = COUNT_EXTRA_S3;
         end
         default: begin
            dlen_in      = '0;
            emit_addr_in = '0;
            addr_idx_in  = ADDR_TOP_S0;
            count_in     = COUNT_EXTRA_S0;
         end
      endcase
   end

   // Read one entry ahead while data pairs go out
   assign emit_data   = cmd.emit && (cmd.phase == PH_DATA);
   assign data_idx_in = cmd.start_record ? '0 :
                        (emit_data ? data_idx_ff + FILL_W'(1) : data_idx_ff);
   assign rd_idx      = (data_idx_in < FILL_W'(RECORD_BYTES)) ?
                        data_idx_in[ADDR_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         buffer_mem[fill_ff[ADDR_W-1:0]] <= item_data_ff;
      end
      rd_data_ff <= buffer_mem[rd_idx];
   end

   // Pair formatting
   always_comb begin
      unique case (cmd.phase)
         PH_COUNT: hex_byte = count_ff;
         PH_ADDR:  hex_byte = emit_addr_ff[{addr_idx_ff, 3'b000} +: 8];
         PH_DATA:  hex_byte = rd_data_ff;
         PH_SUM:   hex_byte = ~sum_ff;
         default:  hex_byte = '0;
      endcase
      unique case (cmd.phase)
         PH_TYPE: begin
            first_in  = CHAR_S;
            second_in = type_char(kind_ff);
         end
         PH_CRLF: begin
            first_in  = CHAR_CR;
            second_in = CHAR_LF;
         end
         default: begin
            first_in  = hex_char(hex_byte[7:4]);
            second_in = hex_char(hex_byte[3:0]);
         end
      endcase
   end

   // Image state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         next_addr_ff <= '0;
         rec_addr_ff  <= '0;
         header_ff    <= 1'b0;
      end else begin
         if (cmd.start_record && cmd.kind == REC_S0) begin
            header_ff    <= 1'b1;
            next_addr_ff <= base_address;
            fill_ff      <= '0;
         end else if (cmd.append) begin
            if (fill_ff == '0) begin
               rec_addr_ff <= next_addr_ff;
            end
            fill_ff      <= fill_ff + FILL_W'(1);
            next_addr_ff <= next_addr_ff + 32'd1;
         end else if (cmd.clr_fill) begin
            fill_ff <= '0;
         end
         if (cmd.clr_header) begin
            header_ff <= 1'b0;
         end
      end
   end

   // Item and record registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_data_ff <= req_data_byte;
         item_has_ff  <= req_has_byte;
         item_eof_ff  <= req_end_of_file;
      end
      data_idx_ff <= data_idx_in;
      if (cmd.start_record) begin
         kind_ff      <= cmd.kind;
         dlen_ff      <= dlen_in;
         count_ff     <= count_in;
         emit_addr_ff <= emit_addr_in;
         addr_idx_ff  <= addr_idx_in;
         sum_ff       <= '0;
      end else if (cmd.emit) begin
         if (cmd.phase == PH_COUNT || cmd.phase == PH_ADDR || cmd.phase == PH_DATA) begin
            sum_ff <= sum_ff + hex_byte;
         end
         if (cmd.phase == PH_ADDR) begin
            addr_idx_ff <= addr_idx_ff - 2'd1;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         first_ff    <= first_in;
         second_ff   <= second_in;
         line_end_ff <= (cmd.phase == PH_CRLF);
         last_ff     <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_char  = first_ff;
   assign rsp_second_char = second_ff;
   assign rsp_line_end    = line_end_ff;
   assign rsp_last_of_run = last_ff;

   always_comb begin
      status.out_free    = !rsp_valid_ff || rsp_ready;
      status.header_sent = header_ff;
      status.fill_zero   = (fill_ff == '0);
      status.fill_full   = (fill_ff == FILL_W'(RECORD_BYTES));
      status.item_has    = item_has_ff;
      status.item_eof    = item_eof_ff;
      status.addr_last   = (addr_idx_ff == 2'd0);
      status.data_last   = (data_idx_ff + FILL_W'(1) == dlen_ff);
      status.data_empty  = (dlen_ff == '0);
      status.kind        = kind_ff;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(RECORD_BYTES))
      else $error("fill count beyond record size");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> (fill_ff < FILL_W'(RECORD_BYTES)))
      else $error("append into a full record");

   a_header_init: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_record && cmd.kind == REC_S0) |=> (fill_ff == '0 && header_ff))
      else $error("header did not restart the image");

endmodule

### rtl/core/srec_record_encoder.sv
// ----------------------------------------------------------------------------
// srec_record_encoder
// Turns a byte stream into Motorola S-record text (S0, S3, S7 records).
//
// Input channel req_chan carries data_byte, has_byte and end_of_file; a
// transaction with neither flag set is taken and ignored. Output channel
// rsp_chan carries one ASCII character pair per transaction; line_end marks
// the CR LF closing a record, last_of_run the final pair of an input item.
// The first item of an image emits the S0 header; every RECORD_BYTES bytes
// make one S3 record; end_of_file flushes a partial record and emits S7
// with base_address. base_address is written over the APB-style port at
// byte address 0; the user must write it only while the block is idle,
// as the block itself does not enforce this. The block takes one input
// item at a time and resumes that item after each record it closes.
// Pairs: 6 for S0, dlen+8 for S3, 8 for S7. The sequencer emits one pair
// per cycle while the output register is free. A stalled receiver holds
// the current pair in the output register and freezes the sequencer.
// Reset clears the image state: the next item starts with a header.
// ----------------------------------------------------------------------------
module srec_record_encoder #(
   parameter int RECORD_BYTES = srec_pkg::RECORD_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   srec_req_if.sink                          req_chan,
   srec_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [srec_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [srec_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [srec_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import srec_pkg::*;

   logic [CSR_DATA_W-1:0] base_ff;
   logic                  base_sel;
   ctrl_cmd_type          cmd;
   ctrl_status_type       status;

   assign base_sel = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_BASE_ADDRESS);
   assign pready   = 1'b1;
   assign prdata   = base_sel ? base_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (psel && penable && pwrite && base_sel) begin
         base_ff <= pwdata;
      end
   end

   srec_ctrl #(
      .RECORD_BYTES(RECORD_BYTES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_has_byte    (req_chan.has_byte),
      .req_end_of_file (req_chan.end_of_file),
      .req_ready       (req_chan.ready),
      .status          (status),
      .cmd             (cmd)
   );

   srec_dp #(
      .RECORD_BYTES(RECORD_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .base_address    (base_ff),
      .req_data_byte   (req_chan.data_byte),
      .req_has_byte    (req_chan.has_byte),
      .req_end_of_file (req_chan.end_of_file),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_first_char  (rsp_chan.first_char),
      .rsp_second_char (rsp_chan.second_char),
      .rsp_line_end    (rsp_chan.line_end),
      .rsp_last_of_run (rsp_chan.last_of_run)
   );

endmodule
